// File: src/p2sp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// p2sp_pkg
// shared types and constants of the planar to semi-planar chroma interleaver
// ----------------------------------------------------------------------------
package p2sp_pkg;

    // configuration register widths
    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 11;

    // default limits
    localparam int MAX_WIDTH_DEF    = 2048;
    localparam int MAX_HEIGHT_DEF   = 1024;
    localparam int CHROMA_DEPTH_DEF = 524288;

    // register map, word index from paddr[3:2]
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_CHROMA_ORDER = 2'd2;

    // chroma order codes
    localparam logic ORDER_NV12 = 1'b0;
    localparam logic ORDER_NV21 = 1'b1;

    // result queue
    localparam int FIFO_DEPTH = 8;

    // plane an input byte belongs to
    typedef enum logic [1:0] {
        KIND_LUMA,
        KIND_CB,
        KIND_CR
    } item_kind_t;

    // one output beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_last;
    } result_t;

endpackage

`default_nettype wire

// File: src/planar_to_semiplanar_chroma_interleave.sv
`default_nettype none
// ----------------------------------------------------------------------------
// planar_to_semiplanar_chroma_interleave
// turns an i420 byte stream into an nv12 or nv21 byte stream
// ----------------------------------------------------------------------------
// usage:
//   s_axis takes the i420 frame one byte per beat: y plane, then u plane, then
//   v plane. y beats go out unchanged, u beats are stored in the chroma ram
//   and give no output, each v beat gives two output beats (u,v for nv12 or
//   v,u for nv21). m_axis carries the output bytes; tuser[0] marks the last
//   beat caused by one input beat, tlast marks the final beat of the frame.
// each input beat passes position decode, chroma ram access and the result
//   queue before its first output beat is valid.
// y and u beats are taken one per cycle while s_axis_tready is high; v beats
//   are slower, set by the single output port draining the result queue.
// the chroma ram is single port, one access per cycle, with a registered read.
// reset clears position, pipeline and queue; the chroma ram is not cleared.
//   the input is held off after reset and after every register write while
//   the frame sizes are recomputed.
// a receiver stall fills the 8-deep result queue; s_axis_tready drops as soon
//   as the queue cannot take the worst case of the beats still in flight.
// registers (apb): 0x0 frame_width, 0x4 frame_height, 0x8 chroma_order.
// ----------------------------------------------------------------------------
module planar_to_semiplanar_chroma_interleave
    import p2sp_pkg::*;
#(
    parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = MAX_HEIGHT_DEF,
    parameter int CHROMA_DEPTH = CHROMA_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,    // [7:0] in_byte
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,    // [7:0] out_byte
    output logic             m_axis_tlast,    // frame_last
    output logic [0:0]       m_axis_tuser     // [0] run_last
);

    // derived widths
    localparam int EW_W   = $clog2(MAX_WIDTH + 1);
    localparam int EH_W   = $clog2(MAX_HEIGHT + 1);
    localparam int WSEL_W = (EW_W > WIDTH_W) ? EW_W : WIDTH_W;
    localparam int HSEL_W = (EH_W > HEIGHT_W) ? EH_W : HEIGHT_W;
    localparam int PROD_W = EW_W + EH_W;
    localparam int POS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT * 3 / 2 + 1);
    localparam int CA_W   = (CHROMA_DEPTH > 1) ? $clog2(CHROMA_DEPTH) : 1;
    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [WSEL_W-1:0] W_MIN = WSEL_W'(2);
    localparam logic [WSEL_W-1:0] W_CAP = WSEL_W'(MAX_WIDTH & ~1);
    localparam logic [HSEL_W-1:0] H_MIN = HSEL_W'(2);
    localparam logic [HSEL_W-1:0] H_CAP = HSEL_W'(MAX_HEIGHT & ~1);
    localparam logic [CNT_W:0]    ROOM_LIMIT = (CNT_W + 1)'(FIFO_DEPTH - 2);

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [WIDTH_W-1:0]  frame_width_reg;
    logic [HEIGHT_W-1:0] frame_height_reg;
    logic                chroma_order_reg;
    logic                cfg_write;
    logic [1:0]          cfg_hold_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_W'(2);
            frame_height_reg <= HEIGHT_W'(2);
            chroma_order_reg <= ORDER_NV12;
            cfg_hold_reg     <= 2'd2;
        end
        else
        begin
            if (cfg_write)
            begin
                // derived sizes are recomputed while the hold counter runs down
                cfg_hold_reg <= 2'd2;
                unique case (paddr[3:2])
                    REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[WIDTH_W-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= pwdata[HEIGHT_W-1:0];
                    REG_CHROMA_ORDER: chroma_order_reg <= pwdata[0];
                    default:          ;
                endcase
            end
            else if (cfg_hold_reg != 2'd0)
            begin
                cfg_hold_reg <= cfg_hold_reg - 2'd1;
            end
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_FRAME_WIDTH:  prdata = 32'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = 32'(frame_height_reg);
            REG_CHROMA_ORDER: prdata = 32'(chroma_order_reg);
            default:          prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------------
    // frame sizes: even, clamped to 2..max rounded down to even, then plane boundaries
    // ------------------------------------------------------------------------
    logic [WSEL_W-1:0] w_even;
    logic [WSEL_W-1:0] w_sel;
    logic [HSEL_W-1:0] h_even;
    logic [HSEL_W-1:0] h_sel;
    logic [EW_W-1:0]   eff_w;
    logic [EH_W-1:0]   eff_h;
    logic [PROD_W-1:0] luma_prod;
    logic [POS_W-1:0]  len_y_reg;
    logic [POS_W-1:0]  cb_end_reg;    // first position of the v plane
    logic [POS_W-1:0]  total_reg;
    logic [POS_W-1:0]  cb_end_next;

    always_comb
    begin
        w_even = WSEL_W'({frame_width_reg[WIDTH_W-1:1], 1'b0});
        h_even = HSEL_W'({frame_height_reg[HEIGHT_W-1:1], 1'b0});
        if (w_even < W_MIN)
            w_sel = W_MIN;
        else if (w_even > W_CAP)
            w_sel = W_CAP;
        else
            w_sel = w_even;
        if (h_even < H_MIN)
            h_sel = H_MIN;
        else if (h_even > H_CAP)
            h_sel = H_CAP;
        else
            h_sel = h_even;
        eff_w       = EW_W'(w_sel);
        eff_h       = EH_W'(h_sel);
        luma_prod   = PROD_W'(eff_w) * PROD_W'(eff_h);
        cb_end_next = len_y_reg + (len_y_reg >> 2);
    end

    always_ff @(posedge clk)
    begin
        len_y_reg  <= POS_W'(luma_prod);
        cb_end_reg <= cb_end_next;
        total_reg  <= cb_end_next + (len_y_reg >> 2);
    end

    // ------------------------------------------------------------------------
    // position decode at the input beat
    // ------------------------------------------------------------------------
    logic             in_beat;
    logic             room_ok;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_start;
    logic [POS_W-1:0] pos_inc;
    logic             at_end;
    logic [POS_W-1:0] idx_full;
    item_kind_t       kind_next;

    logic             s1_valid_reg;
    item_kind_t       s1_kind_reg;
    logic [7:0]       s1_byte_reg;
    logic [CA_W-1:0]  s1_addr_reg;
    logic             s1_ok_reg;
    logic             s1_last_reg;

    logic             s2_valid_reg;
    item_kind_t       s2_kind_reg;
    logic [7:0]       s2_byte_reg;
    logic             s2_ok_reg;
    logic             s2_last_reg;
    logic [7:0]       chroma_rd_reg;

    logic [CNT_W-1:0] fifo_count_reg;

    // the queue must hold every beat still in the pipeline plus this one
    assign room_ok = ((CNT_W + 1)'(fifo_count_reg) + {s1_valid_reg, 1'b0}
                      + {s2_valid_reg, 1'b0}) <= ROOM_LIMIT;
    assign s_axis_tready = (cfg_hold_reg == 2'd0) && room_ok;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        // a size shrink mid frame restarts the position
        pos_start = (pos_reg >= total_reg) ? '0 : pos_reg;
        pos_inc   = pos_start + POS_W'(1);
        at_end    = (pos_inc == total_reg);
        if (pos_start < len_y_reg)
        begin
            kind_next = KIND_LUMA;
            idx_full  = '0;
        end
        else if (pos_start < cb_end_reg)
        begin
            kind_next = KIND_CB;
            idx_full  = pos_start - len_y_reg;
        end
        else
        begin
            kind_next = KIND_CR;
            idx_full  = pos_start - cb_end_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_beat)
            begin
                pos_reg <= at_end ? '0 : pos_inc;
            end
            s1_valid_reg <= in_beat;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg <= kind_next;
        s1_byte_reg <= s_axis_tdata;
        s1_addr_reg <= CA_W'(idx_full);
        s1_ok_reg   <= (32'(idx_full) < 32'(CHROMA_DEPTH));
        s1_last_reg <= at_end;
        s2_kind_reg <= s1_kind_reg;
        s2_byte_reg <= s1_byte_reg;
        s2_ok_reg   <= s1_ok_reg;
        s2_last_reg <= s1_last_reg;
    end

    // ------------------------------------------------------------------------
    // chroma ram: u bytes written, read back by the matching v byte
    // a u write always lands before its v read
    // ------------------------------------------------------------------------
    logic [7:0] chroma_mem [CHROMA_DEPTH];

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_ok_reg && (s1_kind_reg == KIND_CB))
        begin
            chroma_mem[s1_addr_reg] <= s1_byte_reg;
        end
        if (s1_valid_reg && s1_ok_reg && (s1_kind_reg == KIND_CR))
        begin
            chroma_rd_reg <= chroma_mem[s1_addr_reg];
        end
    end

    // ------------------------------------------------------------------------
    // result build and queue
    // ------------------------------------------------------------------------
    result_t          res_a;
    result_t          res_b;
    logic [1:0]       n_push;
    logic [7:0]       cb_byte;
    logic             out_beat;
    result_t          fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_inc;

    always_comb
    begin
        // chroma index beyond the store reads as zero
        cb_byte = s2_ok_reg ? chroma_rd_reg : 8'd0;
        res_a   = '{out_byte: s2_byte_reg, run_last: 1'b1, frame_last: 1'b0};
        res_b   = '{out_byte: s2_byte_reg, run_last: 1'b1, frame_last: s2_last_reg};
        n_push  = 2'd0;
        if (s2_valid_reg)
        begin
            unique case (s2_kind_reg)
                KIND_LUMA:
                begin
                    n_push = 2'd1;
                end
                KIND_CB:
                begin
                    n_push = 2'd0;
                end
                KIND_CR:
                begin
                    n_push = 2'd2;
                    if (chroma_order_reg == ORDER_NV12)
                    begin
                        res_a = '{out_byte: cb_byte, run_last: 1'b0, frame_last: 1'b0};
                        res_b = '{out_byte: s2_byte_reg, run_last: 1'b1,
                                  frame_last: s2_last_reg};
                    end
                    else
                    begin
                        res_a = '{out_byte: s2_byte_reg, run_last: 1'b0, frame_last: 1'b0};
                        res_b = '{out_byte: cb_byte, run_last: 1'b1,
                                  frame_last: s2_last_reg};
                    end
                end
                default:
                begin
                    n_push = 2'd0;
                end
            endcase
        end
    end

    assign wr_ptr_inc = wr_ptr_reg + PTR_W'(1);
    assign out_beat   = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= res_a;
        end
        if (n_push == 2'd2)
        begin
            fifo_mem[wr_ptr_inc] <= res_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_reg + PTR_W'(n_push);
            rd_ptr_reg     <= rd_ptr_reg + PTR_W'(out_beat);
            fifo_count_reg <= fifo_count_reg + CNT_W'(n_push) - CNT_W'(out_beat);
        end
    end

    assign m_axis_tvalid   = (fifo_count_reg != '0);
    assign m_axis_tdata    = fifo_mem[rd_ptr_reg].out_byte;
    assign m_axis_tlast    = fifo_mem[rd_ptr_reg].frame_last;
    assign m_axis_tuser[0] = fifo_mem[rd_ptr_reg].run_last;

`ifndef SYNTHESIS
    // the input reservation must keep the queue from overflowing
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    // the position stays inside the frame after each input beat
    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (pos_reg < total_reg))
        else $error("frame position out of range");

    // the frame end is always the last beat of its input byte
    a_frame_end_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[0])
        else $error("frame end without run end");

    // a chroma ram write and read never share a cycle
    a_ram_single: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_kind_reg == KIND_CB)) |-> !(s1_kind_reg == KIND_CR))
        else $error("chroma ram port conflict");
`endif

endmodule

`default_nettype wire
